>>> design/gdoy_pkg.sv
// ----------------------------------------------------------------------------
// gdoy_pkg
// Shared types, codes and the month table of the day-of-year converter.
// ----------------------------------------------------------------------------
package gdoy_pkg;

   localparam int DEFAULT_YEAR_BITS = 16;
   localparam int RSP_DATA_W        = 24;

   // modular inverse of 25 modulo 2**32
   localparam logic [31:0] INV25 = 32'hC28F5C29;

   localparam logic FUNC_TO_YEARDAY = 1'b0;
   localparam logic FUNC_TO_DATE    = 1'b1;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_BAD_YEAR = 3'd1;
   localparam logic [2:0] STATUS_BAD_MON  = 3'd2;
   localparam logic [2:0] STATUS_BAD_DAY  = 3'd3;
   localparam logic [2:0] STATUS_BAD_YDAY = 3'd4;

   typedef struct packed {
      logic       func;
      logic       year_zero;
      logic       mod4;
      logic       mod16;
      logic [3:0] month;
      logic [4:0] day;
      logic [8:0] yday;
   } item_type;

   typedef struct packed {
      logic       func;
      logic       leap;
      logic [2:0] status;
      logic [3:0] month;
      logic [4:0] day;
      logic [8:0] yday;
   } chk_type;

   typedef struct packed {
      logic [4:0] day;
      logic [3:0] month;
      logic [8:0] yday;
      logic [2:0] status;
   } rsp_type;

   // days before the first of month m in a common year
   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

>>> design/gregorian_day_of_year_converter.sv
// Requests pass the year, check and calc stage registers on their way to rsp_.
// Throughput: one transaction per cycle; stages hold under backpressure.
// Leap test needs a year-bits multiply by the inverse of 25, given a stage.
// Reset clears every stage valid; payload registers are not reset.
// ----------------------------------------------------------------------------
// gregorian_day_of_year_converter
// Converts a date to its day number in a Gregorian year, or back.
// ----------------------------------------------------------------------------
module gregorian_day_of_year_converter #(
   parameter int YEAR_BITS = gdoy_pkg::DEFAULT_YEAR_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // year, month_in, day_in, yearday_in
   input  logic [((YEAR_BITS+18+7)/8)*8-1:0] req_tdata,
   // func
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status, yearday_out, month_out, day_out
   output logic [gdoy_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int MON_LO = YEAR_BITS;
   localparam int DAY_LO = YEAR_BITS + 4;
   localparam int YD_LO  = YEAR_BITS + 9;

   logic                 s1_valid, s1_ready;
   gdoy_pkg::item_type   s1_item;
   logic [YEAR_BITS-1:0] s1_prod;
   logic                 s2_valid, s2_ready;
   gdoy_pkg::chk_type    s2_chk;
   gdoy_pkg::rsp_type    rsp;

   gdoy_year_stage #(
      .YEAR_BITS (YEAR_BITS)
   ) u_year (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (req_tuser),
      .in_year   (req_tdata[YEAR_BITS-1:0]),
      .in_month  (req_tdata[MON_LO +: 4]),
      .in_day    (req_tdata[DAY_LO +: 5]),
      .in_yday   (req_tdata[YD_LO +: 9]),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_item  (s1_item),
      .out_prod  (s1_prod)
   );

   gdoy_check_stage #(
      .YEAR_BITS (YEAR_BITS)
   ) u_check (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_item   (s1_item),
      .in_prod   (s1_prod),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_chk   (s2_chk)
   );

   gdoy_calc_stage u_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_chk    (s2_chk),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {3'd0, rsp};

endmodule

>>> design/gdoy_year_stage.sv
// ----------------------------------------------------------------------------
// gdoy_year_stage
// First stage: capture the transaction and multiply the year by the inverse
// of 25 for the divisibility test.
// ----------------------------------------------------------------------------
module gdoy_year_stage #(
   parameter int YEAR_BITS = gdoy_pkg::DEFAULT_YEAR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_func,
   input  logic [YEAR_BITS-1:0]  in_year,
   input  logic [3:0]            in_month,
   input  logic [4:0]            in_day,
   input  logic [8:0]            in_yday,
   output logic                  out_valid,
   input  logic                  out_ready,
   output gdoy_pkg::item_type    out_item,
   output logic [YEAR_BITS-1:0]  out_prod
);

   localparam logic [YEAR_BITS-1:0] INV = YEAR_BITS'(gdoy_pkg::INV25);

   logic                 valid_ff;
   gdoy_pkg::item_type   item_ff, item_in;
   logic [YEAR_BITS-1:0] prod_ff, prod_in;
   logic                 load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      item_in.func      = in_func;
      item_in.year_zero = (in_year == '0);
      item_in.mod4      = (in_year[1:0] == 2'b00);
      item_in.mod16     = (in_year[3:0] == 4'b0000);
      item_in.month     = in_month;
      item_in.day       = in_day;
      item_in.yday      = in_yday;
      prod_in           = in_year * INV;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_prod  = prod_ff;

endmodule

>>> design/gdoy_check_stage.sv
// ----------------------------------------------------------------------------
// gdoy_check_stage
// Second stage: resolve the leap flag, run the range checks and locate the
// month of a day number.
// ----------------------------------------------------------------------------
module gdoy_check_stage #(
   parameter int YEAR_BITS = gdoy_pkg::DEFAULT_YEAR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  gdoy_pkg::item_type    in_item,
   input  logic [YEAR_BITS-1:0]  in_prod,
   output logic                  out_valid,
   input  logic                  out_ready,
   output gdoy_pkg::chk_type     out_chk
);

   localparam logic [YEAR_BITS-1:0] DIV25_MAX =
      YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / 64'd25);

   logic              valid_ff;
   gdoy_pkg::chk_type chk_ff, chk_in;
   logic              load;
   logic              div25;
   logic              leap;
   logic [10:0]       past;
   logic [8:0]        bound;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      div25 = (in_prod <= DIV25_MAX);
      leap  = (in_item.mod4 && !div25) || (in_item.mod16 && div25);
      for (int k = 0; k < 11; k++) begin
         bound   = gdoy_pkg::days_before(4'(k + 2)) + ((k > 0) ? {8'd0, leap} : 9'd0);
         past[k] = (in_item.yday > bound);
      end

      chk_in.func  = in_item.func;
      chk_in.leap  = leap;
      chk_in.day   = in_item.day;
      chk_in.yday  = in_item.yday;
      chk_in.month = in_item.month;
      if (in_item.func == gdoy_pkg::FUNC_TO_YEARDAY) begin
         if (in_item.year_zero) begin
            chk_in.status = gdoy_pkg::STATUS_BAD_YEAR;
         end else if (in_item.month == 4'd0 || in_item.month > 4'd12) begin
            chk_in.status = gdoy_pkg::STATUS_BAD_MON;
         end else if (in_item.day == 5'd0) begin
            chk_in.status = gdoy_pkg::STATUS_BAD_DAY;
         end else begin
            chk_in.status = gdoy_pkg::STATUS_OK;
         end
      end else begin
         chk_in.month = 4'd1 + 4'($countones(past));
         if (in_item.yday == 9'd0 || in_item.yday > (9'd365 + {8'd0, leap})) begin
            chk_in.status = gdoy_pkg::STATUS_BAD_YDAY;
         end else if (in_item.year_zero) begin
            chk_in.status = gdoy_pkg::STATUS_BAD_YEAR;
         end else begin
            chk_in.status = gdoy_pkg::STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chk_ff <= chk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_chk   = chk_ff;

endmodule

>>> design/gdoy_calc_stage.sv
// ----------------------------------------------------------------------------
// gdoy_calc_stage
// Third stage: add or subtract the days before the month and hold the result
// in the output register.
// ----------------------------------------------------------------------------
module gdoy_calc_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  gdoy_pkg::chk_type  in_chk,
   output logic               out_valid,
   input  logic               out_ready,
   output gdoy_pkg::rsp_type  out_rsp
);

   logic              valid_ff;
   gdoy_pkg::rsp_type rsp_ff, rsp_in;
   logic              load;
   logic [8:0]        lead_days;
   logic [8:0]        diff;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      lead_days = gdoy_pkg::days_before(in_chk.month)
                + ((in_chk.month > 4'd2) ? {8'd0, in_chk.leap} : 9'd0);
      diff      = in_chk.yday - lead_days;

      rsp_in.status = in_chk.status;
      rsp_in.yday   = 9'd0;
      rsp_in.month  = 4'd0;
      rsp_in.day    = 5'd0;
      if (in_chk.status == gdoy_pkg::STATUS_OK) begin
         if (in_chk.func == gdoy_pkg::FUNC_TO_YEARDAY) begin
            rsp_in.yday = lead_days + {4'd0, in_chk.day};
         end else begin
            rsp_in.month = in_chk.month;
            rsp_in.day   = diff[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

>>> test/gregorian_day_of_year_converter_test.sv
// ----------------------------------------------------------------------------
// gregorian_day_of_year_converter_test
// Drives date and day-number conversions through the converter's request
// stream with random gaps and response backpressure, and compares every
// response field against a built-in calendar predictor, in order.
// ----------------------------------------------------------------------------
module gregorian_day_of_year_converter_test;

   localparam int YEAR_BITS = 16;
   localparam int REQ_W     = ((YEAR_BITS + 18 + 7) / 8) * 8;

   class doy_scoreboard;
      gdoy_pkg::rsp_type expected_conversions[$];
      int unsigned mismatches = 0;
      int unsigned month_start [1:12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                          304, 334};

      function automatic int unsigned days_ahead(int unsigned m, int unsigned leap);
         return month_start[m] + ((m > 2) ? leap : 0);
      endfunction

      function automatic gdoy_pkg::rsp_type convert_date(logic f, logic [YEAR_BITS-1:0] y,
                                                         logic [3:0] m, logic [4:0] d,
                                                         logic [8:0] yd);
         gdoy_pkg::rsp_type r;
         int unsigned       leap;
         int unsigned       walk;
         r = '0;
         r.status = gdoy_pkg::STATUS_OK;
         leap = (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 1 : 0;
         if (f == gdoy_pkg::FUNC_TO_YEARDAY) begin
            if (y == 0)
               r.status = gdoy_pkg::STATUS_BAD_YEAR;
            else if (m < 1 || m > 12)
               r.status = gdoy_pkg::STATUS_BAD_MON;
            else if (d < 1)
               r.status = gdoy_pkg::STATUS_BAD_DAY;
            else
               r.yday = 9'(days_ahead(m, leap) + d);
         end else begin
            if (yd < 1 || yd > 365 + leap)
               r.status = gdoy_pkg::STATUS_BAD_YDAY;
            else if (y == 0)
               r.status = gdoy_pkg::STATUS_BAD_YEAR;
            else begin
               walk = 1;
               while (walk < 12 && yd > days_ahead(walk + 1, leap))
                  walk++;
               r.month = 4'(walk);
               r.day   = 5'(yd - days_ahead(walk, leap));
            end
         end
         return r;
      endfunction

      function void note_request(logic f, logic [REQ_W-1:0] data);
         expected_conversions.push_back(convert_date(f, data[YEAR_BITS-1:0],
                                                     data[YEAR_BITS+3:YEAR_BITS],
                                                     data[YEAR_BITS+8:YEAR_BITS+4],
                                                     data[YEAR_BITS+17:YEAR_BITS+9]));
      endfunction

      function void flag(string field, int unsigned want, int unsigned got);
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_response(logic [gdoy_pkg::RSP_DATA_W-1:0] data);
         gdoy_pkg::rsp_type got;
         gdoy_pkg::rsp_type want;
         got = data[$bits(gdoy_pkg::rsp_type)-1:0];
         if (expected_conversions.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none, actual %h", $time, data);
            return;
         end
         want = expected_conversions.pop_front();
         if (got.status !== want.status) flag("status", want.status, got.status);
         if (got.yday !== want.yday) flag("yearday_out", want.yday, got.yday);
         if (got.month !== want.month) flag("month_out", want.month, got.month);
         if (got.day !== want.day) flag("day_out", want.day, got.day);
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [REQ_W-1:0]                req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [gdoy_pkg::RSP_DATA_W-1:0] rsp_tdata;

   doy_scoreboard conversions = new();
   bit            calm = 0;
   bit            hold_off_request = 0;

   gregorian_day_of_year_converter #(.YEAR_BITS(YEAR_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            conversions.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            conversions.check_response(rsp_tdata);
      end
   end

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [YEAR_BITS-1:0] pick_year();
      case ($urandom_range(0, 5))
         0: return YEAR_BITS'(4 * $urandom_range(1, 16383));
         1: return YEAR_BITS'(100 * $urandom_range(1, 655));
         2: return YEAR_BITS'(400 * $urandom_range(1, 163));
         3: return YEAR_BITS'($urandom_range(0, 8));
         default: return YEAR_BITS'($urandom_range(1, 65535));
      endcase
   endfunction

   task automatic offer_conversion(logic f, logic [YEAR_BITS-1:0] y, logic [3:0] m,
                                   logic [4:0] d, logic [8:0] yd);
      int unsigned gap;
      gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= REQ_W'({yd, d, m, y});
      do @(posedge clock); while (!req_tready);
   endtask

   // receiver: random ready bursts and stalls, one long hold-off on request
   initial begin
      int unsigned burst;
      int unsigned stall;
      wait (!reset);
      forever begin
         burst = calm ? 200 : $urandom_range(1, 20);
         rsp_tready <= 1'b1;
         repeat (burst) @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 0;
            stall = 400;
         end else
            stall = idle_length();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int unsigned drain;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // date to day number: checks in year, month, day order
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd0, 4'd5, 5'd10, 9'd0);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd0, 4'd0, 5'd0, 9'd511);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd2023, 4'd0, 5'd1, 9'd0);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd2023, 4'd13, 5'd0, 9'd0);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd2023, 4'd15, 5'd31, 9'd0);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd2023, 4'd6, 5'd0, 9'd100);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd2023, 4'd2, 5'd31, 9'd0);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd2000, 4'd12, 5'd31, 9'd0);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd1900, 4'd12, 5'd31, 9'd0);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd2024, 4'd3, 5'd1, 9'd0);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd65535, 4'd1, 5'd1, 9'd0);
      offer_conversion(gdoy_pkg::FUNC_TO_YEARDAY, 16'd1, 4'd12, 5'd31, 9'd0);
      // day number to date: day number checked before year
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd2023, 4'd15, 5'd31, 9'd0);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd2023, 4'd0, 5'd0, 9'd366);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd2024, 4'd0, 5'd0, 9'd366);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd1900, 4'd0, 5'd0, 9'd366);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd2000, 4'd0, 5'd0, 9'd366);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd2000, 4'd0, 5'd0, 9'd511);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd0, 4'd0, 5'd0, 9'd365);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd0, 4'd0, 5'd0, 9'd366);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd0, 4'd0, 5'd0, 9'd367);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd1, 4'd9, 5'd17, 9'd1);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd2024, 4'd0, 5'd0, 9'd60);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd2023, 4'd0, 5'd0, 9'd60);
      offer_conversion(gdoy_pkg::FUNC_TO_DATE, 16'd65535, 4'd0, 5'd0, 9'd59);

      for (int i = 0; i < 1800; i++) begin
         calm = (i >= 300 && i < 450);
         if (i == 900)
            hold_off_request = 1;
         if ($urandom_range(0, 9) < 7)
            offer_conversion(1'($urandom_range(0, 1)), pick_year(),
                             4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
                             9'($urandom_range(1, 366)));
         else
            offer_conversion(1'($urandom_range(0, 1)), YEAR_BITS'($urandom_range(0, 65535)),
                             4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                             9'($urandom_range(0, 511)));
      end
      calm = 0;
      req_tvalid <= 1'b0;

      drain = 0;
      while (conversions.expected_conversions.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (conversions.expected_conversions.size() != 0) begin
         conversions.mismatches++;
         $display("%0t: responses missing, expected 0 pending, actual %0d", $time,
                  conversions.expected_conversions.size());
      end
      if (conversions.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
design/gdoy_pkg.sv
design/gdoy_year_stage.sv
design/gdoy_check_stage.sv
design/gdoy_calc_stage.sv
design/gregorian_day_of_year_converter.sv
test/gregorian_day_of_year_converter_test.sv
